/* sv/gdpc_pkg.sv */
`default_nettype none

package gdpc_pkg;

   // field widths
   localparam int ACTION_W  = 3;
   localparam int FLOW_W    = 10;
   localparam int TARGET_W  = 24;
   localparam int SECONDS_W = 15;
   localparam int MV_W      = 12;
   localparam int GAS_W     = 11;
   localparam int ACC_W     = 52;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_GAS_FACTOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FLOW   = 1'b1;

   // flow = mv * 1024 / 3000 = (mv << 7) / 375
   localparam int MV_FULL        = 3000;
   localparam int FLOW_SCALE     = 1024;
   localparam int FLOW_MAX       = 1023;
   localparam int FLOW_NUM_SHIFT = 3 + 4;   // 1024 / 8
   localparam int FLOW_DIV       = MV_FULL / 8;
   localparam int NUM_W          = MV_W + FLOW_NUM_SHIFT;
   localparam int RECIP_SHIFT    = 24;
   localparam int RECIP_M        = (1 << RECIP_SHIFT) / FLOW_DIV;
   localparam int RECIP_M_W      = 16;
   localparam int RECIP_P_W      = NUM_W + RECIP_M_W;
   localparam int QEST_W         = RECIP_P_W - RECIP_SHIFT;
   localparam int REM_W          = NUM_W + 1;

   // 61440000 raw units per mm^3 = 1875 << 15
   localparam int RAW_ODD   = 1875;
   localparam int RAW_ODD_W = 11;
   localparam int RAW_SHIFT = 15;

   localparam int PROD1_W = 2 * FLOW_W;
   localparam int INC_W   = PROD1_W + GAS_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_POWER_ON    = 3'd0,
      ACT_POWER_OFF   = 3'd1,
      ACT_DOSE_START  = 3'd2,
      ACT_DOSE_STOP   = 3'd3,
      ACT_PURGE_START = 3'd4,
      ACT_PURGE_STOP  = 3'd5,
      ACT_FAST_TICK   = 3'd6,
      ACT_SLOW_TICK   = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COMPARE,
      ST_FLOW,
      ST_MUL_MAX,
      ST_MUL_GAS,
      ST_ACCUM,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_item;
      logic power_set;
      logic power_clr;
      logic dose_start;
      logic dose_end;
      logic purge_start;
      logic purge_end;
      logic purge_dec;
      logic refuse;
      logic finish;
      logic tgt_mul;
      logic recip_mul;
      logic flow_load;
      logic mul_max;
      logic mul_gas;
      logic acc_add;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       power;
      logic       dose;
      logic       purge;
      logic       cfg_zero;
      logic       setpoint_zero;
      logic       seconds_zero;
      logic       count_zero;
      logic       target_reached;
      logic       rsp_busy;
   } status_type;

endpackage

`default_nettype wire

/* sv/gas_dose_and_purge_controller.sv */
`default_nettype none

// Mass-flow gas dosing controller: power, dose and purge modes driven by one
// command or tick per request transaction, each answered by exactly one
// response transaction carrying the modes, motor duty, last flow code, raw
// delivered volume (1/61440000 mm^3) and purge count. A fast tick during a
// dose raises response valid after decode with the target product, target
// compare with the reciprocal multiply, flow correction and clamp, two chained
// multiplies, the saturating 52-bit add and the response load, or after decode,
// target compare and response load when the target is already reached; every
// other transaction goes from decode straight to the response load. The
// sequencer then returns to idle; a response held by rsp_ready stalls the
// response load of the next transaction. One transaction is in flight at a
// time; the next request is accepted as soon as the sequencer is back in
// idle, even while the previous response is still waiting in the output
// register. Configuration writes (gas_factor at index 0, max_flow at index 1)
// take effect the next cycle and belong in idle periods.
module gas_dose_and_purge_controller #(
   parameter int TARGET_BITS = 24
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [gdpc_pkg::ACTION_W-1:0]     req_action,
   input  wire  [gdpc_pkg::FLOW_W-1:0]       req_flow_setpoint,
   input  wire  [gdpc_pkg::TARGET_W-1:0]     req_target_volume,
   input  wire  [gdpc_pkg::SECONDS_W-1:0]    req_purge_seconds,
   input  wire  [gdpc_pkg::MV_W-1:0]         req_sample_mv,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_power_on,
   output logic                              rsp_dosing,
   output logic                              rsp_purging,
   output logic [gdpc_pkg::FLOW_W-1:0]       rsp_motor_duty,
   output logic [gdpc_pkg::FLOW_W-1:0]       rsp_measured_flow,
   output logic [gdpc_pkg::ACC_W-1:0]        rsp_delivered_raw,
   output logic [gdpc_pkg::SECONDS_W-1:0]    rsp_seconds_left,
   output logic                              rsp_finished,
   input  wire                               csr_we,
   input  wire  [gdpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [gdpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   gdpc_pkg::cmd_type    cmd;
   gdpc_pkg::status_type status;

   gdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdpc_dp #(
      .TARGET_BITS (TARGET_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_flow_setpoint (req_flow_setpoint),
      .req_target_volume (req_target_volume),
      .req_purge_seconds (req_purge_seconds),
      .req_sample_mv     (req_sample_mv),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_power_on      (rsp_power_on),
      .rsp_dosing        (rsp_dosing),
      .rsp_purging       (rsp_purging),
      .rsp_motor_duty    (rsp_motor_duty),
      .rsp_measured_flow (rsp_measured_flow),
      .rsp_delivered_raw (rsp_delivered_raw),
      .rsp_seconds_left  (rsp_seconds_left),
      .rsp_finished      (rsp_finished)
   );

endmodule

`default_nettype wire

/* sv/gdpc_ctrl.sv */
`default_nettype none

module gdpc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  gdpc_pkg::status_type status,
   output gdpc_pkg::cmd_type    cmd
);

   gdpc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gdpc_pkg::ST_IDLE: begin
            if (req_valid) state_in = gdpc_pkg::ST_DECODE;
         end
         gdpc_pkg::ST_DECODE: begin
            if (status.action == gdpc_pkg::ACT_FAST_TICK && status.dose)
               state_in = gdpc_pkg::ST_COMPARE;
            else
               state_in = gdpc_pkg::ST_RESPOND;
         end
         gdpc_pkg::ST_COMPARE: begin
            if (status.target_reached) state_in = gdpc_pkg::ST_RESPOND;
            else state_in = gdpc_pkg::ST_FLOW;
         end
         gdpc_pkg::ST_FLOW:    state_in = gdpc_pkg::ST_MUL_MAX;
         gdpc_pkg::ST_MUL_MAX: state_in = gdpc_pkg::ST_MUL_GAS;
         gdpc_pkg::ST_MUL_GAS: state_in = gdpc_pkg::ST_ACCUM;
         gdpc_pkg::ST_ACCUM:   state_in = gdpc_pkg::ST_RESPOND;
         gdpc_pkg::ST_RESPOND: begin
            if (!status.rsp_busy) state_in = gdpc_pkg::ST_IDLE;
         end
         default: state_in = gdpc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gdpc_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         gdpc_pkg::ST_DECODE: begin
            case (status.action)
               gdpc_pkg::ACT_POWER_ON: cmd.power_set = 1'b1;
               gdpc_pkg::ACT_POWER_OFF: begin
                  cmd.power_clr = 1'b1;
                  cmd.dose_end  = 1'b1;
                  cmd.purge_end = 1'b1;
               end
               gdpc_pkg::ACT_DOSE_START: begin
                  if (!status.power || status.purge || status.cfg_zero || status.setpoint_zero)
                     cmd.refuse = 1'b1;
                  else
                     cmd.dose_start = 1'b1;
               end
               gdpc_pkg::ACT_DOSE_STOP: cmd.dose_end = 1'b1;
               gdpc_pkg::ACT_PURGE_START: begin
                  if (!status.power || status.dose || status.seconds_zero)
                     cmd.refuse = 1'b1;
                  else
                     cmd.purge_start = 1'b1;
               end
               gdpc_pkg::ACT_PURGE_STOP: cmd.purge_end = 1'b1;
               gdpc_pkg::ACT_FAST_TICK: begin
                  if (!status.dose) cmd.refuse = 1'b1;
                  else cmd.tgt_mul = 1'b1;
               end
               gdpc_pkg::ACT_SLOW_TICK: begin
                  if (!status.purge) begin
                     cmd.refuse = 1'b1;
                  end else if (status.count_zero) begin
                     cmd.purge_end = 1'b1;
                     cmd.finish    = 1'b1;
                  end else begin
                     cmd.purge_dec = 1'b1;
                  end
               end
               default: cmd.refuse = 1'b1;
            endcase
         end
         gdpc_pkg::ST_COMPARE: begin
            if (status.target_reached) begin
               cmd.dose_end = 1'b1;
               cmd.finish   = 1'b1;
            end else begin
               cmd.recip_mul = 1'b1;
            end
         end
         gdpc_pkg::ST_FLOW:    cmd.flow_load = 1'b1;
         gdpc_pkg::ST_MUL_MAX: cmd.mul_max   = 1'b1;
         gdpc_pkg::ST_MUL_GAS: cmd.mul_gas   = 1'b1;
         gdpc_pkg::ST_ACCUM:   cmd.acc_add   = 1'b1;
         gdpc_pkg::ST_RESPOND: cmd.rsp_load  = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* sv/gdpc_dp.sv */
`default_nettype none

module gdpc_dp #(
   parameter int TARGET_BITS = 24
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  [gdpc_pkg::ACTION_W-1:0]          req_action,
   input  wire  [gdpc_pkg::FLOW_W-1:0]            req_flow_setpoint,
   input  wire  [gdpc_pkg::TARGET_W-1:0]          req_target_volume,
   input  wire  [gdpc_pkg::SECONDS_W-1:0]         req_purge_seconds,
   input  wire  [gdpc_pkg::MV_W-1:0]              req_sample_mv,
   input  wire                                    csr_we,
   input  wire  [gdpc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [gdpc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  gdpc_pkg::cmd_type                      cmd,
   output gdpc_pkg::status_type                   status,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output logic                                   rsp_accepted,
   output logic                                   rsp_power_on,
   output logic                                   rsp_dosing,
   output logic                                   rsp_purging,
   output logic [gdpc_pkg::FLOW_W-1:0]            rsp_motor_duty,
   output logic [gdpc_pkg::FLOW_W-1:0]            rsp_measured_flow,
   output logic [gdpc_pkg::ACC_W-1:0]             rsp_delivered_raw,
   output logic [gdpc_pkg::SECONDS_W-1:0]         rsp_seconds_left,
   output logic                                   rsp_finished
);

   localparam int TPROD_W = TARGET_BITS + gdpc_pkg::RAW_ODD_W;
   localparam int CMP_W   = (TPROD_W + gdpc_pkg::RAW_SHIFT > gdpc_pkg::ACC_W) ?
                            TPROD_W + gdpc_pkg::RAW_SHIFT : gdpc_pkg::ACC_W;

   // configuration
   logic [gdpc_pkg::GAS_W-1:0]  gas_factor_ff, gas_factor_in;
   logic [gdpc_pkg::FLOW_W-1:0] max_flow_ff, max_flow_in;

   // latched transaction
   gdpc_pkg::action_type           item_action_ff, item_action_in;
   logic [gdpc_pkg::FLOW_W-1:0]    item_setpoint_ff, item_setpoint_in;
   logic [TARGET_BITS-1:0]         item_target_ff, item_target_in;
   logic [gdpc_pkg::SECONDS_W-1:0] item_seconds_ff, item_seconds_in;
   logic [gdpc_pkg::MV_W-1:0]      item_mv_ff, item_mv_in;

   // architectural state
   logic                           power_ff, power_in;
   logic                           dose_ff, dose_in;
   logic                           purge_ff, purge_in;
   logic [gdpc_pkg::FLOW_W-1:0]    setpoint_ff, setpoint_in;
   logic [TARGET_BITS-1:0]         target_ff, target_in;
   logic [gdpc_pkg::ACC_W-1:0]     accum_ff, accum_in;
   logic [gdpc_pkg::FLOW_W-1:0]    flow_ff, flow_in;
   logic [gdpc_pkg::SECONDS_W-1:0] count_ff, count_in;
   logic                           ok_ff, ok_in;
   logic                           done_ff, done_in;

   // arithmetic pipeline
   logic [TPROD_W-1:0]               tprod_ff, tprod_in;
   logic [gdpc_pkg::RECIP_P_W-1:0]   recip_ff, recip_in;
   logic [gdpc_pkg::PROD1_W-1:0]     prod1_ff, prod1_in;
   logic [gdpc_pkg::INC_W-1:0]       inc_ff, inc_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_accepted_ff;
   logic                           rsp_power_ff, rsp_dose_ff, rsp_purge_ff;
   logic [gdpc_pkg::FLOW_W-1:0]    rsp_motor_ff, rsp_flow_ff;
   logic [gdpc_pkg::ACC_W-1:0]     rsp_raw_ff;
   logic [gdpc_pkg::SECONDS_W-1:0] rsp_seconds_ff;
   logic                           rsp_finished_ff;

   logic [31:0]                    tgt_wide;
   logic [CMP_W-1:0]               threshold;
   logic [CMP_W-1:0]               accum_ext;
   logic [gdpc_pkg::NUM_W-1:0]     flow_num;
   logic [gdpc_pkg::QEST_W-1:0]    q_est;
   logic [gdpc_pkg::REM_W-1:0]     q_back;
   logic [gdpc_pkg::REM_W-1:0]     q_rem;
   logic [gdpc_pkg::QEST_W-1:0]    q_fix;
   logic [gdpc_pkg::FLOW_W-1:0]    flow_code;
   logic [gdpc_pkg::ACC_W:0]       acc_sum;

   assign tgt_wide  = 32'(req_target_volume);
   assign threshold = CMP_W'(tprod_ff) << gdpc_pkg::RAW_SHIFT;
   assign accum_ext = CMP_W'(accum_ff);

   // reciprocal divide by 375, corrected by one compare
   assign flow_num = {item_mv_ff, gdpc_pkg::FLOW_NUM_SHIFT'(0)};
   assign q_est    = recip_ff[gdpc_pkg::RECIP_SHIFT +: gdpc_pkg::QEST_W];
   assign q_back   = gdpc_pkg::REM_W'(q_est) * gdpc_pkg::REM_W'(gdpc_pkg::FLOW_DIV);
   assign q_rem    = gdpc_pkg::REM_W'(flow_num) - q_back;
   assign q_fix    = q_est + gdpc_pkg::QEST_W'(q_rem >= gdpc_pkg::REM_W'(gdpc_pkg::FLOW_DIV));
   assign flow_code = (item_mv_ff >= gdpc_pkg::MV_W'(gdpc_pkg::MV_FULL)) ?
                      gdpc_pkg::FLOW_W'(gdpc_pkg::FLOW_MAX) : q_fix[gdpc_pkg::FLOW_W-1:0];

   assign acc_sum = (gdpc_pkg::ACC_W+1)'(accum_ff) + (gdpc_pkg::ACC_W+1)'(inc_ff);

   always_comb begin
      gas_factor_in    = gas_factor_ff;
      max_flow_in      = max_flow_ff;
      item_action_in   = item_action_ff;
      item_setpoint_in = item_setpoint_ff;
      item_target_in   = item_target_ff;
      item_seconds_in  = item_seconds_ff;
      item_mv_in       = item_mv_ff;
      power_in         = power_ff;
      dose_in          = dose_ff;
      purge_in         = purge_ff;
      setpoint_in      = setpoint_ff;
      target_in        = target_ff;
      accum_in         = accum_ff;
      flow_in          = flow_ff;
      count_in         = count_ff;
      ok_in            = ok_ff;
      done_in          = done_ff;
      tprod_in         = tprod_ff;
      recip_in         = recip_ff;
      prod1_in         = prod1_ff;
      inc_in           = inc_ff;

      if (csr_we) begin
         if (csr_index == gdpc_pkg::CSR_GAS_FACTOR)
            gas_factor_in = csr_wdata[gdpc_pkg::GAS_W-1:0];
         if (csr_index == gdpc_pkg::CSR_MAX_FLOW)
            max_flow_in = csr_wdata[gdpc_pkg::FLOW_W-1:0];
      end

      if (cmd.load_item) begin
         item_action_in   = gdpc_pkg::action_type'(req_action);
         item_setpoint_in = req_flow_setpoint;
         item_target_in   = tgt_wide[TARGET_BITS-1:0];
         item_seconds_in  = req_purge_seconds;
         item_mv_in       = req_sample_mv;
         ok_in            = 1'b1;
         done_in          = 1'b0;
      end
      if (cmd.refuse) ok_in = 1'b0;
      if (cmd.finish) done_in = 1'b1;

      if (cmd.power_set) power_in = 1'b1;
      if (cmd.power_clr) power_in = 1'b0;

      if (cmd.dose_start) begin
         dose_in     = 1'b1;
         setpoint_in = item_setpoint_ff;
         target_in   = item_target_ff;
         accum_in    = '0;
      end
      if (cmd.dose_end) begin
         dose_in     = 1'b0;
         setpoint_in = '0;
         target_in   = '0;
      end

      if (cmd.purge_start) begin
         purge_in = 1'b1;
         count_in = item_seconds_ff;
      end
      if (cmd.purge_dec) count_in = count_ff - gdpc_pkg::SECONDS_W'(1);
      if (cmd.purge_end) begin
         purge_in = 1'b0;
         count_in = '0;
      end

      if (cmd.tgt_mul)
         tprod_in = TPROD_W'(target_ff) * TPROD_W'(gdpc_pkg::RAW_ODD);
      if (cmd.recip_mul)
         recip_in = gdpc_pkg::RECIP_P_W'(flow_num) *
                    gdpc_pkg::RECIP_P_W'(gdpc_pkg::RECIP_M);
      if (cmd.flow_load) flow_in = flow_code;
      if (cmd.mul_max)
         prod1_in = gdpc_pkg::PROD1_W'(flow_ff) * gdpc_pkg::PROD1_W'(max_flow_ff);
      if (cmd.mul_gas)
         inc_in = gdpc_pkg::INC_W'(prod1_ff) * gdpc_pkg::INC_W'(gas_factor_ff);
      if (cmd.acc_add) begin
         // saturate at all ones
         if (acc_sum[gdpc_pkg::ACC_W]) accum_in = '1;
         else accum_in = acc_sum[gdpc_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gas_factor_ff <= '0;
         max_flow_ff   <= '0;
         power_ff      <= 1'b0;
         dose_ff       <= 1'b0;
         purge_ff      <= 1'b0;
         setpoint_ff   <= '0;
         target_ff     <= '0;
         accum_ff      <= '0;
         flow_ff       <= '0;
         count_ff      <= '0;
         ok_ff         <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gas_factor_ff <= gas_factor_in;
         max_flow_ff   <= max_flow_in;
         power_ff      <= power_in;
         dose_ff       <= dose_in;
         purge_ff      <= purge_in;
         setpoint_ff   <= setpoint_in;
         target_ff     <= target_in;
         accum_ff      <= accum_in;
         flow_ff       <= flow_in;
         count_ff      <= count_in;
         ok_ff         <= ok_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_action_ff   <= item_action_in;
      item_setpoint_ff <= item_setpoint_in;
      item_target_ff   <= item_target_in;
      item_seconds_ff  <= item_seconds_in;
      item_mv_ff       <= item_mv_in;
      tprod_ff         <= tprod_in;
      recip_ff         <= recip_in;
      prod1_ff         <= prod1_in;
      inc_ff           <= inc_in;
      if (cmd.rsp_load) begin
         rsp_accepted_ff <= ok_ff;
         rsp_power_ff    <= power_ff;
         rsp_dose_ff     <= dose_ff;
         rsp_purge_ff    <= purge_ff;
         rsp_motor_ff    <= dose_ff ? setpoint_ff : '0;
         rsp_flow_ff     <= flow_ff;
         rsp_raw_ff      <= accum_ff;
         rsp_seconds_ff  <= count_ff;
         rsp_finished_ff <= done_ff;
      end
   end

   assign status.action         = item_action_ff;
   assign status.power          = power_ff;
   assign status.dose           = dose_ff;
   assign status.purge          = purge_ff;
   assign status.cfg_zero       = (gas_factor_ff == '0) || (max_flow_ff == '0);
   assign status.setpoint_zero  = (item_setpoint_ff == '0);
   assign status.seconds_zero   = (item_seconds_ff == '0);
   assign status.count_zero     = (count_ff == '0);
   assign status.target_reached = (accum_ext >= threshold);
   assign status.rsp_busy       = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_power_on      = rsp_power_ff;
   assign rsp_dosing        = rsp_dose_ff;
   assign rsp_purging       = rsp_purge_ff;
   assign rsp_motor_duty    = rsp_motor_ff;
   assign rsp_measured_flow = rsp_flow_ff;
   assign rsp_delivered_raw = rsp_raw_ff;
   assign rsp_seconds_left  = rsp_seconds_ff;
   assign rsp_finished      = rsp_finished_ff;

   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(dose_ff && purge_ff))
      else $error("dose and purge active together");

   a_modes_need_power: assert property (@(posedge clock) disable iff (reset)
      (dose_ff || purge_ff) |-> power_ff)
      else $error("mode active without power");

   a_dose_setpoint: assert property (@(posedge clock) disable iff (reset)
      dose_ff |-> (setpoint_ff != '0))
      else $error("dosing with zero setpoint");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response load lost");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 12;   // outlasts the longest sequencer pass
   localparam int DRAIN_LIMIT   = 5000;
   localparam int MAX_REPORTS   = 10;
   localparam int CMD_GOAL      = 600;
   localparam int NUM_PHASES    = 6;
   localparam int DOSE_TICKS    = 40;
   localparam int PURGE_TICKS   = 20;
   localparam longint TIMEOUT_NS = 64'd20_000_000;
   localparam logic [63:0] RAW_PER_MM3 = 64'd61440000;
   localparam logic [63:0] ACC_LIMIT   = (64'd1 << gdpc_pkg::ACC_W) - 64'd1;

   typedef struct packed {
      gdpc_pkg::action_type                 action;
      logic [gdpc_pkg::FLOW_W-1:0]          flow_setpoint;
      logic [gdpc_pkg::TARGET_W-1:0]        target_volume;
      logic [gdpc_pkg::SECONDS_W-1:0]       purge_seconds;
      logic [gdpc_pkg::MV_W-1:0]            sample_mv;
   } gas_cmd_type;

   typedef struct packed {
      logic                                 accepted;
      logic                                 power_on;
      logic                                 dosing;
      logic                                 purging;
      logic [gdpc_pkg::FLOW_W-1:0]          motor_duty;
      logic [gdpc_pkg::FLOW_W-1:0]          measured_flow;
      logic [gdpc_pkg::ACC_W-1:0]           delivered_raw;
      logic [gdpc_pkg::SECONDS_W-1:0]       seconds_left;
      logic                                 finished;
   } ctl_status_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      gas_cmd_type                          cmd;
      logic                                 typed;
      ctl_status_type                       lit;
      logic [gdpc_pkg::CSR_DATA_W-1:0]      gas;
      logic [gdpc_pkg::CSR_DATA_W-1:0]      full;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [gdpc_pkg::ACTION_W-1:0]   req_action;
   logic [gdpc_pkg::FLOW_W-1:0]     req_flow_setpoint;
   logic [gdpc_pkg::TARGET_W-1:0]   req_target_volume;
   logic [gdpc_pkg::SECONDS_W-1:0]  req_purge_seconds;
   logic [gdpc_pkg::MV_W-1:0]       req_sample_mv;
   logic rsp_valid;
   logic rsp_ready;
   logic                            rsp_accepted;
   logic                            rsp_power_on;
   logic                            rsp_dosing;
   logic                            rsp_purging;
   logic [gdpc_pkg::FLOW_W-1:0]     rsp_motor_duty;
   logic [gdpc_pkg::FLOW_W-1:0]     rsp_measured_flow;
   logic [gdpc_pkg::ACC_W-1:0]      rsp_delivered_raw;
   logic [gdpc_pkg::SECONDS_W-1:0]  rsp_seconds_left;
   logic                            rsp_finished;
   logic                            csr_we;
   logic [gdpc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gdpc_pkg::CSR_DATA_W-1:0] csr_wdata;

   // controller state as predicted
   logic [gdpc_pkg::GAS_W-1:0]      cfg_gas;
   logic [gdpc_pkg::FLOW_W-1:0]     cfg_max;
   logic                            pwr;
   logic                            dosing_on;
   logic                            purging_on;
   logic [gdpc_pkg::FLOW_W-1:0]     duty_sp;
   logic [gdpc_pkg::FLOW_W-1:0]     flow_code;
   logic [gdpc_pkg::TARGET_W-1:0]   tgt_mm3;
   logic [gdpc_pkg::ACC_W-1:0]      acc_raw;
   logic [gdpc_pkg::SECONDS_W-1:0]  secs_cnt;

   ctl_status_type status_due_q[$];
   dir_row_type    dir_rows[$];
   int unsigned fail_cnt = 0;
   int unsigned cmd_cnt = 0;
   int          tx_calm = 0;
   bit          quiet = 1'b0;

   gas_dose_and_purge_controller dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void clear_dose();
      dosing_on = 1'b0;
      duty_sp   = '0;
      tgt_mm3   = '0;
   endfunction

   function automatic void clear_purge();
      purging_on = 1'b0;
      secs_cnt   = '0;
   endfunction

   function automatic ctl_status_type next_status(input gas_cmd_type c);
      ctl_status_type s;
      logic [63:0] flow;
      logic [63:0] inc;
      logic        ok;
      logic        fin;
      ok  = 1'b1;
      fin = 1'b0;
      case (c.action)
         gdpc_pkg::ACT_POWER_ON: pwr = 1'b1;
         gdpc_pkg::ACT_POWER_OFF: begin
            clear_purge();
            clear_dose();
            pwr = 1'b0;
         end
         gdpc_pkg::ACT_DOSE_START: begin
            if (!pwr || purging_on || cfg_gas == 0 || cfg_max == 0 || c.flow_setpoint == 0)
            begin
               ok = 1'b0;
            end else begin
               dosing_on = 1'b1;
               duty_sp   = c.flow_setpoint;
               tgt_mm3   = c.target_volume;
               acc_raw   = '0;
            end
         end
         gdpc_pkg::ACT_DOSE_STOP: clear_dose();
         gdpc_pkg::ACT_PURGE_START: begin
            if (!pwr || dosing_on || c.purge_seconds == 0) begin
               ok = 1'b0;
            end else begin
               purging_on = 1'b1;
               secs_cnt   = c.purge_seconds;
            end
         end
         gdpc_pkg::ACT_PURGE_STOP: clear_purge();
         gdpc_pkg::ACT_FAST_TICK: begin
            if (!dosing_on) begin
               ok = 1'b0;
            end else if (64'(acc_raw) >= 64'(tgt_mm3) * RAW_PER_MM3) begin
               // target check comes before this tick's sample is used
               clear_dose();
               fin = 1'b1;
            end else begin
               flow = 64'(c.sample_mv) * 64'(gdpc_pkg::FLOW_SCALE) / 64'(gdpc_pkg::MV_FULL);
               if (flow > 64'(gdpc_pkg::FLOW_MAX)) flow = 64'(gdpc_pkg::FLOW_MAX);
               flow_code = flow[gdpc_pkg::FLOW_W-1:0];
               inc = flow * 64'(cfg_max) * 64'(cfg_gas);
               if (inc > ACC_LIMIT - 64'(acc_raw)) acc_raw = ACC_LIMIT[gdpc_pkg::ACC_W-1:0];
               else acc_raw = acc_raw + inc[gdpc_pkg::ACC_W-1:0];
            end
         end
         default: begin
            if (!purging_on) begin
               ok = 1'b0;
            end else if (secs_cnt == 0) begin
               clear_purge();
               fin = 1'b1;
            end else begin
               secs_cnt = secs_cnt - gdpc_pkg::SECONDS_W'(1);
            end
         end
      endcase
      s.accepted      = ok;
      s.power_on      = pwr;
      s.dosing        = dosing_on;
      s.purging       = purging_on;
      s.motor_duty    = dosing_on ? duty_sp : '0;
      s.measured_flow = flow_code;
      s.delivered_raw = acc_raw;
      s.seconds_left  = secs_cnt;
      s.finished      = fin;
      return s;
   endfunction

   function automatic void show_status(input string tag, input ctl_status_type s);
      $display("   %s: ok=%0b pwr=%0b dose=%0b purge=%0b duty=%0d flow=%0d raw=%0d %s%0d fin=%0b",
               tag, s.accepted, s.power_on, s.dosing, s.purging, s.motor_duty,
               s.measured_flow, s.delivered_raw, "secs=", s.seconds_left, s.finished);
   endfunction

   function automatic gas_cmd_type cmd_of(input gdpc_pkg::action_type a, input int sp,
                                          input int tgt, input int secs, input int mv);
      gas_cmd_type c;
      c.action        = a;
      c.flow_setpoint = gdpc_pkg::FLOW_W'(sp);
      c.target_volume = gdpc_pkg::TARGET_W'(tgt);
      c.purge_seconds = gdpc_pkg::SECONDS_W'(secs);
      c.sample_mv     = gdpc_pkg::MV_W'(mv);
      return c;
   endfunction

   function automatic gdpc_pkg::action_type rand_action();
      return gdpc_pkg::action_type'(gdpc_pkg::ACTION_W'($urandom_range(0, 7)));
   endfunction

   function automatic gas_cmd_type rand_cmd(input gdpc_pkg::action_type a);
      return cmd_of(a, $urandom_range(0, (1 << gdpc_pkg::FLOW_W) - 1),
                    $urandom_range(0, (1 << gdpc_pkg::TARGET_W) - 1),
                    $urandom_range(0, (1 << gdpc_pkg::SECONDS_W) - 1),
                    $urandom_range(0, (1 << gdpc_pkg::MV_W) - 1));
   endfunction

   function automatic ctl_status_type lit_of(input logic ok, input logic on);
      ctl_status_type s;
      s = '0;
      s.accepted = ok;
      s.power_on = on;
      return s;
   endfunction

   function automatic void add_item(input gas_cmd_type c, input logic typed = 1'b0,
                                    input ctl_status_type lit = '0);
      dir_row_type r;
      r       = '0;
      r.kind  = ROW_ITEM;
      r.cmd   = c;
      r.typed = typed;
      r.lit   = lit;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [gdpc_pkg::CSR_DATA_W-1:0] gas,
                                   input logic [gdpc_pkg::CSR_DATA_W-1:0] full);
      dir_row_type r;
      r      = '0;
      r.kind = ROW_CSR;
      r.gas  = gas;
      r.full = full;
      dir_rows.push_back(r);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue_cmd(input gas_cmd_type c, input logic typed = 1'b0,
                            input ctl_status_type lit = '0);
      ctl_status_type due;
      if (!quiet && tx_calm == 0 && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      if (tx_calm > 0) tx_calm--;
      else if ($urandom_range(0, 31) == 0) tx_calm = $urandom_range(10, 40);
      req_valid         <= 1'b1;
      req_action        <= c.action;
      req_flow_setpoint <= c.flow_setpoint;
      req_target_volume <= c.target_volume;
      req_purge_seconds <= c.purge_seconds;
      req_sample_mv     <= c.sample_mv;
      do @(posedge clock); while (!req_ready);
      due = next_status(c);
      if (typed) due = lit;
      status_due_q.push_back(due);
      cmd_cnt++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (status_due_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_cfg(input logic [gdpc_pkg::CSR_DATA_W-1:0] gas,
                            input logic [gdpc_pkg::CSR_DATA_W-1:0] full);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= gdpc_pkg::CSR_GAS_FACTOR;
      csr_wdata <= gas;
      @(negedge clock);
      csr_index <= gdpc_pkg::CSR_MAX_FLOW;
      csr_wdata <= full;
      @(negedge clock);
      csr_we  <= 1'b0;
      cfg_gas = gas[gdpc_pkg::GAS_W-1:0];
      cfg_max = full[gdpc_pkg::FLOW_W-1:0];
   endtask

   task automatic run_session();
      gas_cmd_type c;
      int n;
      n = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (!pwr || $urandom_range(0, 7) == 0)
               issue_cmd(cmd_of(gdpc_pkg::ACT_POWER_ON, 0, 0, 0, 0));
            if (purging_on && $urandom_range(0, 5) != 0)
               issue_cmd(rand_cmd(gdpc_pkg::ACT_PURGE_STOP));
            c = rand_cmd(gdpc_pkg::ACT_DOSE_START);
            c.flow_setpoint = gdpc_pkg::FLOW_W'($urandom_range(1, (1 << gdpc_pkg::FLOW_W) - 1));
            if ($urandom_range(0, 7) != 0)
               c.target_volume = gdpc_pkg::TARGET_W'($urandom_range(0, 40));
            issue_cmd(c);
            while (dosing_on && n < DOSE_TICKS) begin
               if ($urandom_range(0, 15) == 0) issue_cmd(rand_cmd(rand_action()));
               else issue_cmd(rand_cmd(gdpc_pkg::ACT_FAST_TICK));
               n++;
            end
            if (dosing_on) begin
               if ($urandom_range(0, 3) == 0) issue_cmd(rand_cmd(gdpc_pkg::ACT_POWER_OFF));
               else issue_cmd(rand_cmd(gdpc_pkg::ACT_DOSE_STOP));
            end
         end
         4, 5, 6: begin
            if (!pwr || $urandom_range(0, 7) == 0)
               issue_cmd(cmd_of(gdpc_pkg::ACT_POWER_ON, 0, 0, 0, 0));
            if (dosing_on && $urandom_range(0, 5) != 0)
               issue_cmd(rand_cmd(gdpc_pkg::ACT_DOSE_STOP));
            c = rand_cmd(gdpc_pkg::ACT_PURGE_START);
            if ($urandom_range(0, 7) != 0)
               c.purge_seconds = gdpc_pkg::SECONDS_W'($urandom_range(1, 10));
            issue_cmd(c);
            while (purging_on && n < PURGE_TICKS) begin
               if ($urandom_range(0, 15) == 0) issue_cmd(rand_cmd(rand_action()));
               else issue_cmd(rand_cmd(gdpc_pkg::ACT_SLOW_TICK));
               n++;
            end
            if (purging_on) begin
               if ($urandom_range(0, 3) == 0) issue_cmd(rand_cmd(gdpc_pkg::ACT_POWER_OFF));
               else issue_cmd(rand_cmd(gdpc_pkg::ACT_PURGE_STOP));
            end
         end
         default: begin
            repeat ($urandom_range(1, 4)) issue_cmd(rand_cmd(rand_action()));
         end
      endcase
   endtask

   // ready stalls in bursts, with calm stretches in between
   initial begin : rsp_stall_gen
      int hold;
      int calm;
      hold = 0;
      calm = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (quiet || calm > 0) begin
            if (calm > 0) calm--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 80);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            hold = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      ctl_status_type seen;
      ctl_status_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_accepted, rsp_power_on, rsp_dosing, rsp_purging, rsp_motor_duty,
                 rsp_measured_flow, rsp_delivered_raw, rsp_seconds_left, rsp_finished};
         if (status_due_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $display("%0t: response transaction with none outstanding", $time);
         end else begin
            due = status_due_q.pop_front();
            if (seen !== due) begin
               fail_cnt++;
               if (fail_cnt <= MAX_REPORTS) begin
                  $display("%0t: response mismatch", $time);
                  show_status("expected", due);
                  show_status("actual  ", seen);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("gas_dose_and_purge_controller verification failed");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = '0;
      req_flow_setpoint = '0;
      req_target_volume = '0;
      req_purge_seconds = '0;
      req_sample_mv     = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      cfg_gas    = '0;
      cfg_max    = '0;
      pwr        = 1'b0;
      dosing_on  = 1'b0;
      purging_on = 1'b0;
      duty_sp    = '0;
      flow_code  = '0;
      tgt_mm3    = '0;
      acc_raw    = '0;
      secs_cnt   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still zero: ticks and starts are refused with power off and on; power on and stops are accepted
      add_item(cmd_of(gdpc_pkg::ACT_FAST_TICK, 0, 0, 0, 4095), 1'b1, lit_of(1'b0, 1'b0));
      add_item(cmd_of(gdpc_pkg::ACT_SLOW_TICK, 1023, 24'hFFFFFF, 32767, 0), 1'b1,
               lit_of(1'b0, 1'b0));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 1023, 24'hFFFFFF, 0, 0), 1'b1,
               lit_of(1'b0, 1'b0));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 32767, 0), 1'b1, lit_of(1'b0, 1'b0));
      add_item(cmd_of(gdpc_pkg::ACT_POWER_ON, 0, 0, 0, 0), 1'b1, lit_of(1'b1, 1'b1));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 5, 10, 0, 0), 1'b1, lit_of(1'b0, 1'b1));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_STOP, 0, 0, 0, 0), 1'b1, lit_of(1'b1, 1'b1));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_STOP, 0, 0, 0, 0), 1'b1, lit_of(1'b1, 1'b1));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 0, 0), 1'b1, lit_of(1'b0, 1'b1));
      // purge runs down to zero, then the next tick finishes it
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 2, 0));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 7, 5, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_SLOW_TICK, 0, 0, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_SLOW_TICK, 0, 0, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_SLOW_TICK, 0, 0, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 32767, 0));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 3, 0));
      add_item(cmd_of(gdpc_pkg::ACT_POWER_OFF, 0, 0, 0, 0));
      add_csr(11'h7FF, 11'h7FF);
      add_item(cmd_of(gdpc_pkg::ACT_POWER_ON, 0, 0, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 0, 5, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 1023, 0, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_FAST_TICK, 0, 0, 0, 4095));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 1, 1, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_FAST_TICK, 0, 0, 0, 4095));
      add_item(cmd_of(gdpc_pkg::ACT_PURGE_START, 0, 0, 100, 0));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_START, 512, 24'hFFFFFF, 0, 0));
      add_item(cmd_of(gdpc_pkg::ACT_FAST_TICK, 0, 0, 0, 2930));
      add_item(cmd_of(gdpc_pkg::ACT_DOSE_STOP, 0, 0, 0, 0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) write_cfg(dir_rows[i].gas, dir_rows[i].full);
         else issue_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].lit);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: write_cfg(11'd1, 11'd1);
            1: write_cfg(11'd0, gdpc_pkg::CSR_DATA_W'($urandom_range(0, 2047)));
            // stray top bit, max zero
            2: write_cfg(gdpc_pkg::CSR_DATA_W'($urandom_range(1, 2047)), {1'b1, 10'd0});
            default: write_cfg(gdpc_pkg::CSR_DATA_W'($urandom_range(1, 2047)),
                               gdpc_pkg::CSR_DATA_W'($urandom_range(0, 2047)));
         endcase
         if (ph == NUM_PHASES - 1) quiet = 1'b1;
         while (cmd_cnt < CMD_GOAL * (ph + 1) / NUM_PHASES) run_session();
      end

      wait_drained();
      if (status_due_q.size() != 0) begin
         $display("%0d expected responses never arrived", status_due_q.size());
         fail_cnt += status_due_q.size();
      end
      if (fail_cnt == 0)
         $display("gas_dose_and_purge_controller verification clean");
      else
         $display("gas_dose_and_purge_controller verification failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/gdpc_pkg.sv
sv/gdpc_ctrl.sv
sv/gdpc_dp.sv
sv/gas_dose_and_purge_controller.sv
tb/sv/tb_top.sv
